/* hdl/free_list_slot_table_with_key_search_assert.svh */
// assertion macros for the slot table, clocked on clk and held off during reset
`ifndef FREE_LIST_SLOT_TABLE_WITH_KEY_SEARCH_ASSERT_SVH
`define FREE_LIST_SLOT_TABLE_WITH_KEY_SEARCH_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FLST_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slot table check failed");

// consequent must hold in the cycle after the antecedent
`define FLST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slot table check failed");

`endif

/* hdl/flst_pkg.sv */
package flst_pkg;

	// default table depth
	localparam int SLOTS_DEF = 64;

	// fixed field widths
	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 6;
	localparam int INDEX_W  = 6;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_REG    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UNREG  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

	// strobes from the sequencer to the slot store
	typedef struct packed {
		logic rd_en;
		logic key_we;
		logic use_we;
		logic use_wd;
		logic link_we;
	} flst_mem_ctl_t;

endpackage

/* hdl/flst_store.sv */
module flst_store #(
	parameter int SLOTS = flst_pkg::SLOTS_DEF,
	parameter int IDX_W = $clog2(SLOTS),
	parameter int PTR_W = $clog2(SLOTS + 1)
) (
	input  logic                       clk,
	input  flst_pkg::flst_mem_ctl_t    ctl,
	input  logic [IDX_W-1:0]           waddr,
	input  logic [IDX_W-1:0]           raddr,
	input  logic [flst_pkg::KEY_W-1:0] key_wd,
	input  logic [PTR_W-1:0]           link_wd,
	output logic [flst_pkg::KEY_W-1:0] key_rd,
	output logic                       use_rd,
	output logic [PTR_W-1:0]           link_rd
);
	import flst_pkg::*;

	logic [KEY_W-1:0] key_mem [SLOTS];
	logic             use_mem [SLOTS];
	logic [PTR_W-1:0] link_mem [SLOTS];

	// one write port, shared address
	always_ff @(posedge clk) begin
		if (ctl.key_we) begin
			key_mem[waddr] <= key_wd;
		end
		if (ctl.use_we) begin
			use_mem[waddr] <= ctl.use_wd;
		end
		if (ctl.link_we) begin
			link_mem[waddr] <= link_wd;
		end
	end

	// one registered read port, shared address
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			key_rd  <= key_mem[raddr];
			use_rd  <= use_mem[raddr];
			link_rd <= link_mem[raddr];
		end
	end

endmodule

/* hdl/free_list_slot_table_with_key_search.sv */
// register: done from idle when slots remain unused, via S_POP when popping the free list
// unregister: idle result for a never allocated handle, else S_CHK reads the in-use store
// lookup: scans only the used slots, where used is the count ever allocated (<= SLOTS)
// one entry per cycle through the single read port and the shared 32-bit key compare
// a new command is taken the cycle after done is computed; results are one-cycle strobes
// reset clears in-use tracking through the fill count: no clearing pass, ready at once
module free_list_slot_table_with_key_search #(
	parameter int SLOTS = flst_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [flst_pkg::CMD_W-1:0]    command,
	input  logic [flst_pkg::KEY_W-1:0]    entity_key,
	input  logic [flst_pkg::HANDLE_W-1:0] slot_handle,
	output logic                          done,
	output logic [flst_pkg::INDEX_W-1:0]  slot_index,
	output logic                          found,
	output logic [flst_pkg::STATUS_W-1:0] status
);
	import flst_pkg::*;

	`include "free_list_slot_table_with_key_search_assert.svh"

	localparam int IDX_W = $clog2(SLOTS);
	localparam int PTR_W = $clog2(SLOTS + 1);
	localparam int CW    = (PTR_W > HANDLE_W) ? PTR_W : HANDLE_W;
	localparam int OW    = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
	localparam logic [PTR_W-1:0] END_PTR = PTR_W'(SLOTS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_CHK  = 2'd2;
	localparam logic [1:0] S_SCAN = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [PTR_W-1:0] free_head_q, free_head_d;
	logic [PTR_W-1:0] ever_q, ever_d;
	logic [PTR_W-1:0] scan_q, scan_d;
	logic             cmp_valid_q, cmp_valid_d;
	logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [IDX_W-1:0] handle_q, handle_d;

	logic                done_q;
	logic [INDEX_W-1:0]  slot_index_q;
	logic                found_q;
	logic [STATUS_W-1:0] status_q;

	flst_mem_ctl_t    mem_ctl;
	logic [IDX_W-1:0] waddr, raddr;
	logic [KEY_W-1:0] key_wd, key_rd;
	logic [PTR_W-1:0] link_wd, link_rd;
	logic             use_rd;

	logic                accept;
	logic [CW-1:0]       handle_ext, ever_ext;
	logic                res_v, res_found;
	logic [IDX_W-1:0]    res_idx;
	logic [OW-1:0]       res_idx_ext;
	logic [STATUS_W-1:0] res_st;
	logic                key_hit;

	flst_store #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W),
		.PTR_W (PTR_W)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.waddr   (waddr),
		.raddr   (raddr),
		.key_wd  (key_wd),
		.link_wd (link_wd),
		.key_rd  (key_rd),
		.use_rd  (use_rd),
		.link_rd (link_rd)
	);

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign handle_ext = CW'(slot_handle);
	assign ever_ext   = CW'(ever_q);
	// shared key compare, one stored entry per cycle
	assign key_hit    = cmp_valid_q && use_rd && (key_rd == key_q);

	// sequencer
	always_comb begin
		mem_ctl     = '0;
		waddr       = '0;
		raddr       = '0;
		key_wd      = key_q;
		link_wd     = free_head_q;
		res_v       = 1'b0;
		res_found   = 1'b0;
		res_idx     = '0;
		res_st      = ST_OK;
		state_d     = state_q;
		free_head_d = free_head_q;
		ever_d      = ever_q;
		scan_d      = scan_q;
		cmp_valid_d = cmp_valid_q;
		cmp_idx_d   = cmp_idx_q;
		key_d       = key_q;
		handle_d    = handle_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					key_d    = entity_key;
					handle_d = handle_ext[IDX_W-1:0];
					unique case (command)
						CMD_REG: begin
							if (free_head_q != END_PTR) begin
								mem_ctl.rd_en = 1'b1;
								raddr         = free_head_q[IDX_W-1:0];
								state_d       = S_POP;
							end else if (ever_q != END_PTR) begin
								mem_ctl.key_we = 1'b1;
								mem_ctl.use_we = 1'b1;
								mem_ctl.use_wd = 1'b1;
								waddr          = ever_q[IDX_W-1:0];
								key_wd         = entity_key;
								ever_d         = PTR_W'(ever_q + 1'b1);
								res_v          = 1'b1;
								res_found      = 1'b1;
								res_idx        = ever_q[IDX_W-1:0];
							end else begin
								res_v  = 1'b1;
								res_st = ST_FULL;
							end
						end
						CMD_UNREG: begin
							// a handle at or above the fill count was never allocated
							if (handle_ext < ever_ext) begin
								mem_ctl.rd_en = 1'b1;
								raddr         = handle_ext[IDX_W-1:0];
								state_d       = S_CHK;
							end else begin
								res_v  = 1'b1;
								res_st = ST_NOT_USED;
							end
						end
						CMD_LOOKUP: begin
							if (ever_q == '0) begin
								res_v = 1'b1;
							end else begin
								scan_d      = '0;
								cmp_valid_d = 1'b0;
								state_d     = S_SCAN;
							end
						end
						default: begin
							res_v = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				// take the free list head, link now read
				mem_ctl.key_we = 1'b1;
				mem_ctl.use_we = 1'b1;
				mem_ctl.use_wd = 1'b1;
				waddr          = free_head_q[IDX_W-1:0];
				free_head_d    = link_rd;
				res_v          = 1'b1;
				res_found      = 1'b1;
				res_idx        = free_head_q[IDX_W-1:0];
				state_d        = S_IDLE;
			end
			S_CHK: begin
				// release and push onto the free list if in use
				if (use_rd) begin
					mem_ctl.use_we  = 1'b1;
					mem_ctl.link_we = 1'b1;
					waddr           = handle_q;
					link_wd         = free_head_q;
					free_head_d     = PTR_W'(handle_q);
				end else begin
					res_st = ST_NOT_USED;
				end
				res_v   = 1'b1;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				// compare the entry read last cycle, issue the next read
				if (key_hit) begin
					res_v     = 1'b1;
					res_found = 1'b1;
					res_idx   = cmp_idx_q;
					state_d   = S_IDLE;
				end else if (scan_q == ever_q) begin
					res_v   = 1'b1;
					state_d = S_IDLE;
				end else begin
					mem_ctl.rd_en = 1'b1;
					raddr         = scan_q[IDX_W-1:0];
					cmp_idx_d     = scan_q[IDX_W-1:0];
					cmp_valid_d   = 1'b1;
					scan_d        = PTR_W'(scan_q + 1'b1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res_idx_ext = OW'(res_idx);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_head_q <= END_PTR;
			ever_q      <= '0;
			scan_q      <= '0;
			cmp_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			free_head_q <= free_head_d;
			ever_q      <= ever_d;
			scan_q      <= scan_d;
			cmp_valid_q <= cmp_valid_d;
			done_q      <= res_v;
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		key_q     <= key_d;
		handle_q  <= handle_d;
		cmp_idx_q <= cmp_idx_d;
		if (res_v) begin
			slot_index_q <= res_idx_ext[INDEX_W-1:0];
			found_q      <= res_found;
			status_q     <= res_st;
		end
	end

	assign done       = done_q;
	assign slot_index = slot_index_q;
	assign found      = found_q;
	assign status     = status_q;

	// an accepted command is either in work or has its result beat next cycle
	`FLST_ASSERT_NEXT(a_accept_progress, accept, busy || done)
	// a hit is only reported with an ok status
	`FLST_ASSERT_SAME(a_found_ok, done && found, status == ST_OK)
	// list head and fill count stay within the table
	`FLST_ASSERT_SAME(a_ptr_bounds, 1'b1, (free_head_q <= END_PTR) && (ever_q <= END_PTR))
	// the scan never runs past the filled region
	`FLST_ASSERT_SAME(a_scan_bound, state_q == S_SCAN, scan_q <= ever_q)

endmodule

/* tb/free_list_slot_table_with_key_search_tb.sv */
module free_list_slot_table_with_key_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import flst_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 80;
	// command code the block has no meaning for
	localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} slot_cmd_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  slot_index;
		logic                found;
		logic [STATUS_W-1:0] status;
	} slot_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [CMD_W-1:0]    command = CMD_REG;
	logic [KEY_W-1:0]    entity_key = '0;
	logic [HANDLE_W-1:0] slot_handle = '0;
	logic                busy;
	logic                done;
	logic [INDEX_W-1:0]  slot_index;
	logic                found;
	logic [STATUS_W-1:0] status;

	slot_cmd_t   cmd_queue[$];
	slot_reply_t expected_replies[$];
	slot_reply_t want_reply;
	int          idle_pct = 0;
	int          mismatches = 0;
	int          stall_cycles = 0;

	// shadow copy of the table
	logic [KEY_W-1:0] tbl_key [SLOTS];
	logic             tbl_in_use [SLOTS] = '{default: 1'b0};
	int unsigned      tbl_link [SLOTS];
	int unsigned      tbl_head = SLOTS;
	int unsigned      tbl_fill = 0;

	logic [KEY_W-1:0] key_pool [12] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
		32'hDEAD_BEEF, 32'h8000_0000, 32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555,
		32'h0000_00FF, 32'hFF00_0000, 32'h7FFF_FFFF, 32'hCAFE_F00D};

	free_list_slot_table_with_key_search #(
		.SLOTS(SLOTS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.entity_key (entity_key),
		.slot_handle(slot_handle),
		.done       (done),
		.slot_index (slot_index),
		.found      (found),
		.status     (status)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// reset, once
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// apply one command to the shadow table and return the reply it gives
	function automatic slot_reply_t slot_table_step(slot_cmd_t c);
		slot_reply_t r;
		int unsigned idx;
		int unsigned i;
		r = '0;
		r.status = ST_OK;
		case (c.cmd)
			CMD_REG: begin
				if (tbl_head < SLOTS) begin
					idx = tbl_head;
					tbl_head = (tbl_link[idx] > SLOTS) ? SLOTS : tbl_link[idx];
				end else if (tbl_fill < SLOTS) begin
					// appended slot takes the count before growth
					idx = tbl_fill;
					tbl_fill++;
				end else begin
					r.status = ST_FULL;
					return r;
				end
				tbl_key[idx] = c.key;
				tbl_in_use[idx] = 1'b1;
				r.slot_index = idx[INDEX_W-1:0];
				r.found = 1'b1;
			end
			CMD_UNREG: begin
				if (int'(c.handle) >= SLOTS || !tbl_in_use[c.handle]) begin
					r.status = ST_NOT_USED;
				end else begin
					tbl_link[c.handle] = tbl_head;
					tbl_in_use[c.handle] = 1'b0;
					tbl_head = 32'(c.handle);
				end
			end
			CMD_LOOKUP: begin
				// first in-use match in ascending order
				for (i = 0; i < tbl_fill && i < SLOTS; i++) begin
					if (tbl_in_use[i] && tbl_key[i] == c.key) begin
						r.slot_index = i[INDEX_W-1:0];
						r.found = 1'b1;
						return r;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
		logic [HANDLE_W-1:0] handle);
		slot_cmd_t c;
		c.cmd = cmd;
		c.key = key;
		c.handle = handle;
		cmd_queue.push_back(c);
	endtask

	// sender holds off until every beat is taken and every reply is back
	task automatic drain;
		while (cmd_queue.size() != 0 || expected_replies.size() != 0) @(posedge clk);
	endtask

	// random commands with a given mix, then drained
	task automatic run_phase(int n, int reg_pct, int unreg_pct, int look_pct, int idle);
		int k;
		int roll;
		logic [CMD_W-1:0]    cmd;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		idle_pct = idle;
		for (k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < reg_pct)
				cmd = CMD_REG;
			else if (roll < reg_pct + unreg_pct)
				cmd = CMD_UNREG;
			else if (roll < reg_pct + unreg_pct + look_pct)
				cmd = CMD_LOOKUP;
			else
				cmd = CMD_BAD;
			// pool keys give duplicates and lookup hits
			key = $urandom_range(0, 1) ? key_pool[$urandom_range(0, 11)] : $urandom();
			handle = HANDLE_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
				: $urandom_range(0, 63));
			push_cmd(cmd, key, handle);
		end
		drain();
	endtask

	// stimulus
	initial begin
		while (!arst_n) @(posedge clk);

		// directed: empty table, extremes, duplicates, free list reuse
		idle_pct = 0;
		push_cmd(CMD_LOOKUP, 32'h0000_0000, 6'd0);
		push_cmd(CMD_UNREG,  32'h0000_0000, 6'd0);
		push_cmd(CMD_UNREG,  32'hFFFF_FFFF, 6'd63);
		push_cmd(CMD_BAD,    32'hFFFF_FFFF, 6'd63);
		push_cmd(CMD_REG,    32'h0000_0000, 6'd0);
		push_cmd(CMD_REG,    32'hFFFF_FFFF, 6'd63);
		push_cmd(CMD_REG,    32'h1234_5678, 6'd0);
		push_cmd(CMD_REG,    32'h0000_0000, 6'd0);
		push_cmd(CMD_LOOKUP, 32'h0000_0000, 6'd0);
		push_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0);
		push_cmd(CMD_LOOKUP, 32'hDEAD_BEEF, 6'd0);
		push_cmd(CMD_UNREG,  32'h0000_0000, 6'd0);
		push_cmd(CMD_LOOKUP, 32'h0000_0000, 6'd0);
		push_cmd(CMD_UNREG,  32'h0000_0000, 6'd0);
		push_cmd(CMD_LOOKUP, 32'h1234_5678, 6'd0);
		push_cmd(CMD_UNREG,  32'h0000_0000, 6'd2);
		push_cmd(CMD_UNREG,  32'h0000_0000, 6'd1);
		push_cmd(CMD_REG,    32'hAAAA_AAAA, 6'd0);
		push_cmd(CMD_REG,    32'h5555_5555, 6'd0);
		push_cmd(CMD_REG,    32'h0000_0001, 6'd0);
		push_cmd(CMD_REG,    32'h8000_0000, 6'd0);
		push_cmd(CMD_LOOKUP, 32'h1234_5678, 6'd0);
		push_cmd(CMD_LOOKUP, 32'h8000_0000, 6'd0);
		push_cmd(CMD_BAD,    32'h0000_0000, 6'd0);
		push_cmd(CMD_UNREG,  32'h0000_0000, 6'd4);
		drain();

		// fill up to a full table and beyond
		run_phase(90, 90, 4, 5, 26);
		// steady churn with a mostly idle sender
		run_phase(200, 35, 35, 27, 81);
		// release heavy, back to back
		run_phase(120, 10, 70, 15, 0);
		// mixed churn
		run_phase(215, 40, 30, 27, 26);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0)
			report_mismatch($sformatf("%0d replies never came", expected_replies.size()));
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// driver: a beat is taken when start is high and busy low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			command <= CMD_REG;
			entity_key <= '0;
			slot_handle <= '0;
		end else begin
			if (start && !busy)
				expected_replies.push_back(slot_table_step(cmd_queue.pop_front()));
			// line is free: nothing offered, or the offered beat just went
			if (!start || !busy) begin
				if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					start <= 1'b1;
					command <= cmd_queue[0].cmd;
					entity_key <= cmd_queue[0].key;
					slot_handle <= cmd_queue[0].handle;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: each strobe checked against the oldest outstanding reply
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("reply with nothing outstanding");
			end else begin
				want_reply = expected_replies.pop_front();
				if (slot_index !== want_reply.slot_index)
					report_mismatch($sformatf("slot_index %0d, wanted %0d",
						slot_index, want_reply.slot_index));
				if (found !== want_reply.found)
					report_mismatch($sformatf("found %0b, wanted %0b", found, want_reply.found));
				if (status !== want_reply.status)
					report_mismatch($sformatf("status %0d, wanted %0d",
						status, want_reply.status));
			end
		end
	end

	// watchdog on cycles with no beat and no reply
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d quiet cycles", stall_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
